### src/mexp_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the modular add for the modular exponentiation block
package mexp_pkg;

    // operand width and derived counter widths
    localparam int OPW    = 31;
    localparam int CNT_W  = $clog2(OPW);
    localparam int MCNT_W = $clog2(OPW + 1);
    localparam int STEP_W = 4;

    localparam logic [OPW-1:0] MODULUS_RESET = OPW'(1000000007);

    typedef logic [OPW-1:0]    operand_t;
    typedef logic [STEP_W-1:0] step_t;

    // action carried out by one control word
    typedef enum logic [2:0] {
        ACT_NOP    = 3'd0,
        ACT_ACCEPT = 3'd1,
        ACT_MUL    = 3'd2,
        ACT_ONE    = 3'd3,
        ACT_DEC    = 3'd4,
        ACT_ZERO   = 3'd5,
        ACT_EMIT   = 3'd6
    } act_t;

    // multiplier operand routing
    typedef enum logic [1:0] {
        MSEL_RED  = 2'd0,
        MSEL_SQR  = 2'd1,
        MSEL_BASE = 2'd2
    } msel_t;

    // jump condition
    typedef enum logic [2:0] {
        COND_NEXT     = 3'd0,
        COND_JUMP     = 3'd1,
        COND_SMALL_M  = 3'd2,
        COND_EBIT_CLR = 3'd3,
        COND_CNT_ZERO = 3'd4
    } cond_t;

    typedef struct packed {
        act_t  act;
        msel_t msel;
        cond_t cond;
        step_t target;
    } ucode_t;

    // multiplier status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    // program step addresses
    localparam step_t STEP_ACCEPT = 4'd0;
    localparam step_t STEP_CHECK  = 4'd1;
    localparam step_t STEP_REDUCE = 4'd2;
    localparam step_t STEP_INIT   = 4'd3;
    localparam step_t STEP_SQUARE = 4'd4;
    localparam step_t STEP_TEST   = 4'd5;
    localparam step_t STEP_MULT   = 4'd6;
    localparam step_t STEP_LAST   = 4'd7;
    localparam step_t STEP_DEC    = 4'd8;
    localparam step_t STEP_ZERO   = 4'd9;
    localparam step_t STEP_EMIT   = 4'd10;

    // (a + b) mod m for a, b below m
    function automatic operand_t add_mod(input operand_t a, input operand_t b,
                                         input operand_t m);
        logic [OPW:0] s;
        logic [OPW:0] t;
        s = {1'b0, a} + {1'b0, b};
        t = s - {1'b0, m};
        return (s >= {1'b0, m}) ? t[OPW-1:0] : s[OPW-1:0];
    endfunction

endpackage

### src/mexp_in_if.sv
`timescale 1ns / 1ps
// input channel: base and exponent with valid/ready
interface mexp_in_if;
    import mexp_pkg::*;

    logic     valid;
    logic     ready;
    operand_t base;
    operand_t exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink   (input valid, input base, input exponent, output ready);
endinterface

### src/mexp_out_if.sv
`timescale 1ns / 1ps
// output channel: power with valid/ready
interface mexp_out_if;
    import mexp_pkg::*;

    logic     valid;
    logic     ready;
    operand_t power;

    modport source (output valid, output power, input ready);
    modport sink   (input valid, input power, output ready);
endinterface

### src/mexp_ucode.sv
`timescale 1ns / 1ps
// control store holding the square-and-multiply program
module mexp_ucode (
    input  mexp_pkg::step_t  pc,
    output mexp_pkg::ucode_t uc
);
    import mexp_pkg::*;

    // one control word per step
    always_comb
    begin
        unique case (pc)
            STEP_ACCEPT: uc = '{ACT_ACCEPT, MSEL_SQR,  COND_NEXT,     STEP_ACCEPT};
            STEP_CHECK:  uc = '{ACT_NOP,    MSEL_SQR,  COND_SMALL_M,  STEP_ZERO};
            STEP_REDUCE: uc = '{ACT_MUL,    MSEL_RED,  COND_NEXT,     STEP_ACCEPT};
            STEP_INIT:   uc = '{ACT_ONE,    MSEL_SQR,  COND_NEXT,     STEP_ACCEPT};
            STEP_SQUARE: uc = '{ACT_MUL,    MSEL_SQR,  COND_NEXT,     STEP_ACCEPT};
            STEP_TEST:   uc = '{ACT_NOP,    MSEL_SQR,  COND_EBIT_CLR, STEP_LAST};
            STEP_MULT:   uc = '{ACT_MUL,    MSEL_BASE, COND_NEXT,     STEP_ACCEPT};
            STEP_LAST:   uc = '{ACT_NOP,    MSEL_SQR,  COND_CNT_ZERO, STEP_EMIT};
            STEP_DEC:    uc = '{ACT_DEC,    MSEL_SQR,  COND_JUMP,     STEP_SQUARE};
            STEP_ZERO:   uc = '{ACT_ZERO,   MSEL_SQR,  COND_NEXT,     STEP_ACCEPT};
            STEP_EMIT:   uc = '{ACT_EMIT,   MSEL_SQR,  COND_JUMP,     STEP_ACCEPT};
            default:     uc = '{ACT_NOP,    MSEL_SQR,  COND_JUMP,     STEP_ACCEPT};
        endcase
    end
endmodule

### src/mexp_mulmod.sv
`timescale 1ns / 1ps
// bit-serial msb-first shift-and-add modular multiplier, one bit of y per cycle
module mexp_mulmod (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  mexp_pkg::operand_t  x,
    input  mexp_pkg::operand_t  y,
    input  mexp_pkg::operand_t  m,
    output mexp_pkg::operand_t  product,
    output mexp_pkg::mul_stat_t stat
);
    import mexp_pkg::*;

    operand_t          acc_reg;
    operand_t          x_reg;
    operand_t          y_reg;
    logic [MCNT_W-1:0] cnt_reg;
    logic              done_reg;
    operand_t          dbl;
    operand_t          acc_next;

    // double, then add x where the current bit of y is set
    always_comb
    begin
        dbl      = add_mod(acc_reg, acc_reg, m);
        acc_next = y_reg[OPW-1] ? add_mod(dbl, x_reg, m) : dbl;
    end

    // bit counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= MCNT_W'(OPW);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - MCNT_W'(1);
            done_reg <= (cnt_reg == MCNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // operand and accumulator registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            x_reg   <= x;
            y_reg   <= y;
        end
        else if (cnt_reg != '0)
        begin
            acc_reg <= acc_next;
            y_reg   <= {y_reg[OPW-2:0], 1'b0};
        end
    end

    assign product   = acc_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
endmodule

### src/modular_exponentiation.sv
`timescale 1ns / 1ps
// Modular exponentiation: power = base ** exponent mod modulus, by square-and-multiply.
// An item (base, exponent) is taken on the input channel with a valid/ready transfer;
// one result (power) leaves on the output channel with a valid/ready transfer.
// The user must write the modulus through wr_en / wr_data only while the block is
// idle; the block does not enforce this. Reset loads 1000000007. A modulus of 0 or 1
// gives power 0. A microcoded sequencer steps a short program; every product goes
// through one shared bit-serial modular multiplier, one multiplier bit per cycle.
// The base is reduced first with the same unit. One item is in work at a time;
// input ready is high only while the sequencer waits for an item. The result sits
// in an output register, so the sequencer returns to the input while a result waits;
// a finished result stalls in the emit step until the output register is free.
// Reset clears the sequencer and empties the output register.
module modular_exponentiation (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  mexp_pkg::operand_t wr_data,
    mexp_in_if.sink            item,
    mexp_out_if.source         result
);
    import mexp_pkg::*;

    step_t            pc_reg;
    step_t            pc_next;
    operand_t         mod_reg;
    operand_t         base_reg;
    operand_t         exp_reg;
    operand_t         acc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             out_valid_reg;
    operand_t         out_power_reg;

    ucode_t    uc;
    mul_stat_t mul_stat;
    logic      mul_start;
    operand_t  mul_x;
    operand_t  mul_y;
    operand_t  mul_product;
    logic      step_done;
    logic      jump;

    // control store
    mexp_ucode u_ucode (
        .pc (pc_reg),
        .uc (uc)
    );

    // shared modular multiplier
    mexp_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .x       (mul_x),
        .y       (mul_y),
        .m       (mod_reg),
        .product (mul_product),
        .stat    (mul_stat)
    );

    // operand routing
    always_comb
    begin
        unique case (uc.msel)
            MSEL_RED:
            begin
                mul_x = OPW'(1);
                mul_y = base_reg;
            end
            MSEL_BASE:
            begin
                mul_x = base_reg;
                mul_y = acc_reg;
            end
            default:
            begin
                mul_x = acc_reg;
                mul_y = acc_reg;
            end
        endcase
    end

    assign mul_start = (uc.act == ACT_MUL) && !mul_stat.busy && !mul_stat.done;

    // step completion
    always_comb
    begin
        unique case (uc.act)
            ACT_ACCEPT: step_done = item.valid;
            ACT_MUL:    step_done = mul_stat.done;
            ACT_EMIT:   step_done = !out_valid_reg || result.ready;
            default:    step_done = 1'b1;
        endcase
    end

    // jump condition
    always_comb
    begin
        unique case (uc.cond)
            COND_JUMP:     jump = 1'b1;
            COND_SMALL_M:  jump = (mod_reg < OPW'(2));
            COND_EBIT_CLR: jump = !exp_reg[cnt_reg];
            COND_CNT_ZERO: jump = (cnt_reg == '0);
            default:       jump = 1'b0;
        endcase
    end

    // step counter
    always_comb
    begin
        if (!step_done)
            pc_next = pc_reg;
        else if (jump)
            pc_next = uc.target;
        else
            pc_next = pc_reg + STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= STEP_ACCEPT;
        else
            pc_reg <= pc_next;
    end

    // modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mod_reg <= MODULUS_RESET;
        else if (wr_en)
            mod_reg <= wr_data;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (uc.act)
            ACT_ACCEPT:
            begin
                if (item.valid)
                begin
                    base_reg <= item.base;
                    exp_reg  <= item.exponent;
                end
            end
            ACT_MUL:
            begin
                if (mul_stat.done)
                begin
                    if (uc.msel == MSEL_RED)
                        base_reg <= mul_product;
                    else
                        acc_reg <= mul_product;
                end
            end
            ACT_ONE:
            begin
                acc_reg <= OPW'(1);
                cnt_reg <= CNT_W'(OPW - 1);
            end
            ACT_DEC:  cnt_reg <= cnt_reg - CNT_W'(1);
            ACT_ZERO: acc_reg <= '0;
            default:  ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((uc.act == ACT_EMIT) && step_done)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if ((uc.act == ACT_EMIT) && step_done)
            out_power_reg <= acc_reg;
    end

    assign item.ready   = (uc.act == ACT_ACCEPT);
    assign result.valid = out_valid_reg;
    assign result.power = out_power_reg;

    // the multiplier is never restarted while a product is in work
    assert property (@(posedge clk) disable iff (!rst_n) mul_start |-> !mul_stat.busy)
        else $error("multiplier started while busy");

    // a product is handed back only after the multiplier has been working
    assert property (@(posedge clk) disable iff (!rst_n) mul_stat.done |-> $past(mul_stat.busy))
        else $error("multiplier done without work");

    // the value emitted is fully reduced when the modulus is at least 2
    assert property (@(posedge clk) disable iff (!rst_n)
        (uc.act == ACT_EMIT) && (mod_reg >= OPW'(2)) |-> (acc_reg < mod_reg))
        else $error("result not reduced modulo the modulus");
endmodule
